@@ design/srrip_pkg.sv @@
// shared types and constants for the srrip/fifo dueling replacement engine
// no dependencies; used by every module of the block but srrip_ram, by scoped names

package srrip_pkg;

    localparam int NUM_SETS   = 2048;
    localparam int SET_W      = 11;
    localparam int NUM_WAYS   = 16;
    localparam int WAY_W      = 4;
    localparam int AGE_W      = 32;
    localparam int STAT_W     = 32;
    localparam int CNT_W      = 20;
    localparam int RRPV_W     = 2;
    localparam int PERIOD_W   = 5;
    localparam int PERIOD_MAX = 20;
    localparam int RRPV_ROW_W = NUM_WAYS * RRPV_W;
    localparam int AGE_ROW_W  = NUM_WAYS * AGE_W;
    localparam int QUEUE_DEPTH = 2;

    localparam logic [RRPV_W-1:0] RRPV_MAX    = 2'd3;
    localparam logic [RRPV_W-1:0] RRPV_INSERT = 2'd2;
    localparam logic [RRPV_W-1:0] RRPV_HIT    = 2'd0;
    localparam logic [STAT_W-1:0] STAT_MAX    = {STAT_W{1'b1}};
    localparam logic [AGE_W-1:0]  AGE_MAX     = {AGE_W{1'b1}};

    localparam logic [SET_W-1:0]    LEADERS_RESET = 11'd32;
    localparam logic [PERIOD_W-1:0] PERIOD_RESET  = 5'd12;

    // command codes
    localparam logic CMD_QUERY  = 1'b0;
    localparam logic CMD_UPDATE = 1'b1;

    // policy codes
    localparam logic POL_SRRIP = 1'b0;
    localparam logic POL_FIFO  = 1'b1;

    // configuration register indexes
    localparam logic CFG_LEADERS = 1'b0;
    localparam logic CFG_PERIOD  = 1'b1;

    // classified item handed from front to back
    typedef struct packed {
        logic             cmd;
        logic [SET_W-1:0] set_index;
        logic [WAY_W-1:0] way_index;
        logic             was_hit;
        logic             srrip_leader;
        logic             fifo_leader;
    } item_t;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_REDUCE,
        ST_APPLY,
        ST_MUL_A,
        ST_MUL_B,
        ST_DECIDE
    } back_state_t;

endpackage

@@ design/srrip_fifo_dueling_replacement_top.sv @@
// top level of the srrip/fifo dueling replacement engine
// depends on srrip_pkg, srrip_front, srrip_queue and srrip_back
//
// usage:
//   s_* channel carries one request beat: a victim query or an access update
//   for one cache set. m_* channel returns exactly one result beat per request:
//   the victim way (0 for updates) and the policy the set used.
//   cfg_* channel writes leader_sets_each (index 0) or period_log2 (index 1);
//   write only while the engine is idle.
// request path:
//   a request passes through the queue, the row read, the group search and
//   the apply step before its result beat. a follower update that lands on a
//   switch interval then keeps the back part occupied with the two hit-rate
//   cross products and the policy write; its own result is not delayed. the
//   back part works one set row at a time and takes the next beat only when
//   it is back in idle with the output register empty.
// reset:
//   after rst_n releases, a clearing pass writes all 2048 set rows, one per
//   cycle; s_tready stays low until the pass is done.
// stall:
//   a result waits in the output register while m_tready is low; the front
//   keeps taking beats into its two-entry queue until it fills.

module srrip_fifo_dueling_replacement_top (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,    // set_index[10:0], way_index[14:11], was_hit[15]
    input  logic        s_tuser,    // cmd
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,    // victim_way[3:0], zero fill[7:4]
    output logic        m_tuser,    // policy_used
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic        cfg_index,
    input  logic [10:0] cfg_data
);

    logic                           busy;
    logic                           q_full, q_push, q_pop, q_valid;
    srrip_pkg::item_t               q_in, q_out;
    logic [srrip_pkg::PERIOD_W-1:0] period_log2;

    // accept and classify
    srrip_front u_front (
        .clk(clk), .rst_n(rst_n),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
        .cfg_data(cfg_data), .busy(busy), .q_full(q_full), .q_push(q_push),
        .q_data(q_in), .period_log2(period_log2)
    );

    // decoupling queue
    srrip_queue u_queue (
        .clk(clk), .rst_n(rst_n), .push(q_push), .push_data(q_in), .full(q_full),
        .pop(q_pop), .not_empty(q_valid), .pop_data(q_out)
    );

    // set row engine
    srrip_back u_back (
        .clk(clk), .rst_n(rst_n), .period_log2(period_log2),
        .q_valid(q_valid), .q_data(q_out), .q_pop(q_pop), .busy(busy),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
    );

    // no push into a full queue
    assert property (@(posedge clk) disable iff (!rst_n) q_push |-> !q_full)
        else $error("queue overflow");

    // no pop from an empty queue
    assert property (@(posedge clk) disable iff (!rst_n) q_pop |-> q_valid)
        else $error("queue underflow");

    // no input taken during the clearing pass
    assert property (@(posedge clk) disable iff (!rst_n) busy |-> !q_push)
        else $error("beat accepted while clearing");

    // no pop while a result is stalled in the output register
    assert property (@(posedge clk) disable iff (!rst_n) (m_tvalid && !m_tready) |-> !q_pop)
        else $error("pop while result pending");

endmodule

@@ design/srrip_ram.sv @@
// generic simple dual-port ram, one write and one registered read port
// no dependencies

module srrip_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // registered read, holds when idle
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

@@ design/srrip_queue.sv @@
// short queue of classified items between the front and back parts
// depends on srrip_pkg

module srrip_queue (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  push,
    input  srrip_pkg::item_t      push_data,
    output logic                  full,
    input  logic                  pop,
    output logic                  not_empty,
    output srrip_pkg::item_t      pop_data
);

    srrip_pkg::item_t slot_reg [srrip_pkg::QUEUE_DEPTH];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;

    assign full      = (count_reg == 2'(srrip_pkg::QUEUE_DEPTH));
    assign not_empty = (count_reg != 2'd0);
    assign pop_data  = slot_reg[rd_ptr_reg];

    // pointer and count update
    always_comb
    begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + 2'(push) - 2'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // payload storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

@@ design/srrip_front.sv @@
// front part: configuration registers, input beat acceptance, leader classification
// depends on srrip_pkg

module srrip_front (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [15:0]                     s_tdata,
    input  logic                            s_tuser,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic                            cfg_index,
    input  logic [srrip_pkg::SET_W-1:0]     cfg_data,
    input  logic                            busy,
    input  logic                            q_full,
    output logic                            q_push,
    output srrip_pkg::item_t                q_data,
    output logic [srrip_pkg::PERIOD_W-1:0]  period_log2
);

    logic [srrip_pkg::SET_W-1:0]    leaders_reg;
    logic [srrip_pkg::PERIOD_W-1:0] period_reg;
    logic [srrip_pkg::SET_W-1:0]    set_idx;
    logic [srrip_pkg::SET_W:0]      twice_leaders;

    assign cfg_ready   = 1'b1;
    assign period_log2 = period_reg;
    assign s_tready    = !busy && !q_full;
    assign q_push      = s_tvalid && s_tready;

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            leaders_reg <= srrip_pkg::LEADERS_RESET;
            period_reg  <= srrip_pkg::PERIOD_RESET;
        end
        else if (cfg_valid)
        begin
            if (cfg_index == srrip_pkg::CFG_LEADERS)
            begin
                leaders_reg <= cfg_data;
            end
            else
            begin
                period_reg <= cfg_data[srrip_pkg::PERIOD_W-1:0];
            end
        end
    end

    // classify the set as srrip leader, fifo leader or follower
    always_comb
    begin
        set_idx       = s_tdata[10:0];
        twice_leaders = {leaders_reg, 1'b0};
        q_data.cmd          = s_tuser;
        q_data.set_index    = set_idx;
        q_data.way_index    = s_tdata[14:11];
        q_data.was_hit      = s_tdata[15];
        q_data.srrip_leader = (set_idx < leaders_reg);
        q_data.fifo_leader  = !(set_idx < leaders_reg)
                              && ({1'b0, set_idx} < twice_leaders);
    end

endmodule

@@ design/srrip_back.sv @@
// back part: set row read-modify-write, victim search, statistics, follower policy choice
// depends on srrip_pkg and srrip_ram

module srrip_back (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic [srrip_pkg::PERIOD_W-1:0]  period_log2,
    input  logic                            q_valid,
    input  srrip_pkg::item_t                q_data,
    output logic                            q_pop,
    output logic                            busy,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [7:0]                      m_tdata,
    output logic                            m_tuser
);

    localparam int SW = srrip_pkg::SET_W;
    localparam int NW = srrip_pkg::NUM_WAYS;
    localparam int AW = srrip_pkg::AGE_W;
    localparam int RW = srrip_pkg::RRPV_W;
    localparam int TW = srrip_pkg::STAT_W;
    localparam int WW = srrip_pkg::WAY_W;
    localparam int GROUPS = 4;
    localparam int GSIZE  = NW / GROUPS;

    srrip_pkg::back_state_t state_reg, state_next;

    // ram ports
    logic                             rd_en;
    logic                             row_wr_en, pol_wr_en;
    logic [SW-1:0]                    row_wr_addr, pol_wr_addr;
    logic [srrip_pkg::RRPV_ROW_W-1:0] rrpv_wdata, rrpv_rdata, rrpv_new;
    logic [srrip_pkg::AGE_ROW_W-1:0]  age_wdata, age_rdata, age_new;
    logic                             pol_wdata, pol_rdata;

    logic [SW-1:0]  clr_reg;
    srrip_pkg::item_t item_reg;
    logic           policy_reg;
    logic [AW-1:0]  grp_age_reg [GROUPS];
    logic [WW-1:0]  grp_way_reg [GROUPS];
    logic [TW-1:0]  s_hits_reg, s_acc_reg, f_hits_reg, f_acc_reg;
    logic [srrip_pkg::CNT_W-1:0] count_reg, count_next;
    logic [2*TW-1:0] prod_a_reg, prod_b_reg;
    logic           out_valid_reg;
    logic [WW-1:0]  out_way_reg;
    logic           out_pol_reg;

    // apply-stage signals
    logic [AW-1:0]  grp_age [GROUPS];
    logic [WW-1:0]  grp_way [GROUPS];
    logic [AW-1:0]  best_age;
    logic [WW-1:0]  age_victim, rrpv_victim, victim;
    logic [RW-1:0]  best_rrpv;
    logic           any3, any2, any1;
    logic           found;
    logic [RW-1:0]  way_rrpv;
    logic [AW-1:0]  way_age;
    logic [srrip_pkg::PERIOD_W-1:0] period_eff;
    logic [srrip_pkg::CNT_W-1:0]    period_mask;
    logic           need_decide;
    logic           is_update, leader_item;
    logic           policy_now;
    logic [TW-1:0]  sn, sd, fn, fd;

    srrip_ram #(.WIDTH(srrip_pkg::RRPV_ROW_W), .DEPTH(srrip_pkg::NUM_SETS)) u_rrpv_ram (
        .clk(clk), .wr_en(row_wr_en), .wr_addr(row_wr_addr), .wr_data(rrpv_wdata),
        .rd_en(rd_en), .rd_addr(q_data.set_index), .rd_data(rrpv_rdata)
    );

    srrip_ram #(.WIDTH(srrip_pkg::AGE_ROW_W), .DEPTH(srrip_pkg::NUM_SETS)) u_age_ram (
        .clk(clk), .wr_en(row_wr_en), .wr_addr(row_wr_addr), .wr_data(age_wdata),
        .rd_en(rd_en), .rd_addr(q_data.set_index), .rd_data(age_rdata)
    );

    srrip_ram #(.WIDTH(1), .DEPTH(srrip_pkg::NUM_SETS)) u_pol_ram (
        .clk(clk), .wr_en(pol_wr_en), .wr_addr(pol_wr_addr), .wr_data(pol_wdata),
        .rd_en(rd_en), .rd_addr(q_data.set_index), .rd_data(pol_rdata)
    );

    assign is_update = (item_reg.cmd == srrip_pkg::CMD_UPDATE);
    assign leader_item = item_reg.srrip_leader || item_reg.fifo_leader;
    assign policy_now = item_reg.srrip_leader ? srrip_pkg::POL_SRRIP
                      : item_reg.fifo_leader  ? srrip_pkg::POL_FIFO : pol_rdata;

    // first way of greatest age within each group of four
    always_comb
    begin
        for (int g = 0; g < GROUPS; g++)
        begin
            grp_age[g] = age_rdata[g*GSIZE*AW +: AW];
            grp_way[g] = WW'(g*GSIZE);
            for (int k = 1; k < GSIZE; k++)
            begin
                if (age_rdata[(g*GSIZE+k)*AW +: AW] > grp_age[g])
                begin
                    grp_age[g] = age_rdata[(g*GSIZE+k)*AW +: AW];
                    grp_way[g] = WW'(g*GSIZE + k);
                end
            end
        end
    end

    // final age search over the group winners
    always_comb
    begin
        best_age   = grp_age_reg[0];
        age_victim = grp_way_reg[0];
        for (int g = 1; g < GROUPS; g++)
        begin
            if (grp_age_reg[g] > best_age)
            begin
                best_age   = grp_age_reg[g];
                age_victim = grp_way_reg[g];
            end
        end
    end

    // highest rrpv and the first way holding it
    always_comb
    begin
        any3 = 1'b0;
        any2 = 1'b0;
        any1 = 1'b0;
        for (int w = 0; w < NW; w++)
        begin
            any3 = any3 | (rrpv_rdata[w*RW +: RW] == 2'd3);
            any2 = any2 | (rrpv_rdata[w*RW +: RW] == 2'd2);
            any1 = any1 | (rrpv_rdata[w*RW +: RW] == 2'd1);
        end
        best_rrpv   = any3 ? 2'd3 : any2 ? 2'd2 : any1 ? 2'd1 : 2'd0;
        rrpv_victim = '0;
        found       = 1'b0;
        for (int w = 0; w < NW; w++)
        begin
            if (!found && rrpv_rdata[w*RW +: RW] == best_rrpv)
            begin
                rrpv_victim = WW'(w);
                found       = 1'b1;
            end
        end
    end

    // new row contents
    always_comb
    begin
        rrpv_new = rrpv_rdata;
        age_new  = age_rdata;
        way_rrpv = srrip_pkg::RRPV_MAX;
        way_age  = '0;
        if (!is_update)
        begin
            if (policy_reg == srrip_pkg::POL_SRRIP)
            begin
                for (int w = 0; w < NW; w++)
                begin
                    rrpv_new[w*RW +: RW] = rrpv_rdata[w*RW +: RW]
                                           + (srrip_pkg::RRPV_MAX - best_rrpv);
                end
            end
        end
        else if (policy_reg == srrip_pkg::POL_SRRIP)
        begin
            way_rrpv = item_reg.was_hit ? srrip_pkg::RRPV_HIT : srrip_pkg::RRPV_INSERT;
            rrpv_new[item_reg.way_index*RW +: RW] = way_rrpv;
            age_new[item_reg.way_index*AW +: AW]  = way_age;
        end
        else if (item_reg.was_hit)
        begin
            age_new[item_reg.way_index*AW +: AW] = way_age;
        end
        else
        begin
            for (int w = 0; w < NW; w++)
            begin
                if (age_rdata[w*AW +: AW] != srrip_pkg::AGE_MAX)
                begin
                    age_new[w*AW +: AW] = age_rdata[w*AW +: AW] + 1'b1;
                end
            end
            age_new[item_reg.way_index*AW +: AW]  = way_age;
            rrpv_new[item_reg.way_index*RW +: RW] = way_rrpv;
        end
        victim = is_update ? '0
               : (policy_reg == srrip_pkg::POL_SRRIP) ? rrpv_victim : age_victim;
    end

    // switch interval check for follower updates
    always_comb
    begin
        count_next  = count_reg + 1'b1;
        period_eff  = (period_log2 > srrip_pkg::PERIOD_W'(srrip_pkg::PERIOD_MAX))
                      ? srrip_pkg::PERIOD_W'(srrip_pkg::PERIOD_MAX) : period_log2;
        period_mask = ~({srrip_pkg::CNT_W{1'b1}} << period_eff);
        need_decide = is_update && !leader_item && ((count_next & period_mask) == '0);
        sn = (s_acc_reg != '0) ? s_hits_reg : '0;
        sd = (s_acc_reg != '0) ? s_acc_reg : TW'(1);
        fn = (f_acc_reg != '0) ? f_hits_reg : '0;
        fd = (f_acc_reg != '0) ? f_acc_reg : TW'(1);
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            srrip_pkg::ST_CLEAR:
            begin
                if (clr_reg == SW'(srrip_pkg::NUM_SETS - 1))
                begin
                    state_next = srrip_pkg::ST_IDLE;
                end
            end
            srrip_pkg::ST_IDLE:
            begin
                if (q_valid && !out_valid_reg)
                begin
                    state_next = srrip_pkg::ST_REDUCE;
                end
            end
            srrip_pkg::ST_REDUCE: state_next = srrip_pkg::ST_APPLY;
            srrip_pkg::ST_APPLY:
            begin
                state_next = need_decide ? srrip_pkg::ST_MUL_A : srrip_pkg::ST_IDLE;
            end
            srrip_pkg::ST_MUL_A:  state_next = srrip_pkg::ST_MUL_B;
            srrip_pkg::ST_MUL_B:  state_next = srrip_pkg::ST_DECIDE;
            srrip_pkg::ST_DECIDE: state_next = srrip_pkg::ST_IDLE;
            default:              state_next = srrip_pkg::ST_IDLE;
        endcase
    end

    // state outputs and ram controls
    always_comb
    begin
        busy        = 1'b0;
        q_pop       = 1'b0;
        rd_en       = 1'b0;
        row_wr_en   = 1'b0;
        row_wr_addr = item_reg.set_index;
        rrpv_wdata  = rrpv_new;
        age_wdata   = age_new;
        pol_wr_en   = 1'b0;
        pol_wr_addr = item_reg.set_index;
        pol_wdata   = (prod_a_reg >= prod_b_reg) ? srrip_pkg::POL_SRRIP : srrip_pkg::POL_FIFO;
        case (state_reg)
            srrip_pkg::ST_CLEAR:
            begin
                busy        = 1'b1;
                row_wr_en   = 1'b1;
                row_wr_addr = clr_reg;
                rrpv_wdata  = {srrip_pkg::RRPV_ROW_W{1'b1}};
                age_wdata   = '0;
                pol_wr_en   = 1'b1;
                pol_wr_addr = clr_reg;
                pol_wdata   = srrip_pkg::POL_SRRIP;
            end
            srrip_pkg::ST_IDLE:
            begin
                q_pop = q_valid && !out_valid_reg;
                rd_en = q_valid && !out_valid_reg;
            end
            srrip_pkg::ST_APPLY:  row_wr_en = 1'b1;
            srrip_pkg::ST_DECIDE: pol_wr_en = 1'b1;
            default:
            begin
                busy = 1'b0;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= srrip_pkg::ST_CLEAR;
            clr_reg       <= '0;
            out_valid_reg <= 1'b0;
            count_reg     <= '0;
            s_hits_reg    <= '0;
            s_acc_reg     <= '0;
            f_hits_reg    <= '0;
            f_acc_reg     <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == srrip_pkg::ST_CLEAR)
            begin
                clr_reg <= clr_reg + 1'b1;
            end
            if (state_reg == srrip_pkg::ST_APPLY)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
            // statistics and access count
            if (state_reg == srrip_pkg::ST_APPLY && is_update)
            begin
                count_reg <= count_next;
                if (leader_item && policy_reg == srrip_pkg::POL_SRRIP)
                begin
                    if (s_acc_reg != srrip_pkg::STAT_MAX)
                        s_acc_reg <= s_acc_reg + 1'b1;
                    if (item_reg.was_hit && s_hits_reg != srrip_pkg::STAT_MAX)
                        s_hits_reg <= s_hits_reg + 1'b1;
                end
                else if (leader_item)
                begin
                    if (f_acc_reg != srrip_pkg::STAT_MAX)
                        f_acc_reg <= f_acc_reg + 1'b1;
                    if (item_reg.was_hit && f_hits_reg != srrip_pkg::STAT_MAX)
                        f_hits_reg <= f_hits_reg + 1'b1;
                end
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            item_reg <= q_data;
        end
        if (state_reg == srrip_pkg::ST_REDUCE)
        begin
            policy_reg <= policy_now;
            for (int g = 0; g < GROUPS; g++)
            begin
                grp_age_reg[g] <= grp_age[g];
                grp_way_reg[g] <= grp_way[g];
            end
        end
        if (state_reg == srrip_pkg::ST_APPLY)
        begin
            out_way_reg <= victim;
            out_pol_reg <= policy_reg;
        end
        // cross products, one multiplier use per cycle
        if (state_reg == srrip_pkg::ST_MUL_A)
        begin
            prod_a_reg <= sn * fd;
        end
        if (state_reg == srrip_pkg::ST_MUL_B)
        begin
            prod_b_reg <= fn * sd;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {4'b0, out_way_reg};
    assign m_tuser  = out_pol_reg;

endmodule

@@ tb/srrip_fifo_dueling_replacement_top_tb.sv @@
// self-checking bench for srrip_fifo_dueling_replacement_top, with its own
// copy of the policy state and random request and result stalls
// depends on srrip_pkg and the top level of the replacement engine

module srrip_fifo_dueling_replacement_top_tb;

    typedef struct {
        logic                        cmd;
        logic [srrip_pkg::SET_W-1:0] set_index;
        logic [srrip_pkg::WAY_W-1:0] way_index;
        logic                        was_hit;
    } request_t;

    typedef struct {
        logic [srrip_pkg::WAY_W-1:0] victim;
        logic                        policy;
    } result_t;

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [15:0] s_tdata;    // set_index[10:0], way_index[14:11], was_hit[15]
    logic        s_tuser;    // cmd
    logic        m_tvalid;
    logic        m_tready;
    logic [7:0]  m_tdata;    // victim_way[3:0], zero fill[7:4]
    logic        m_tuser;    // policy_used
    logic        cfg_valid;
    logic        cfg_ready;
    logic        cfg_index;
    logic [10:0] cfg_data;

    // predicted engine state
    logic [srrip_pkg::RRPV_W-1:0] rrpv_row [srrip_pkg::NUM_SETS][srrip_pkg::NUM_WAYS];
    logic [srrip_pkg::AGE_W-1:0]  age_row [srrip_pkg::NUM_SETS][srrip_pkg::NUM_WAYS];
    logic                         set_policy [srrip_pkg::NUM_SETS];
    logic [srrip_pkg::STAT_W-1:0] srrip_hits, srrip_accesses, fifo_hits, fifo_accesses;
    logic [srrip_pkg::CNT_W-1:0]  access_count;
    logic [srrip_pkg::SET_W-1:0]  leaders_each;
    logic [srrip_pkg::PERIOD_W-1:0] period_log2;

    request_t pending_req [$];
    result_t  expected_result [$];
    int       error_count;
    bit       hold_send;
    bit       no_idle;
    bit       in_taken;
    int       send_gap;
    int       recv_gap;

    srrip_fifo_dueling_replacement_top uut (.*);

    always #5 clk = ~clk;

    // mostly short gaps, a few long ones
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (no_idle || r < 50) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    function automatic logic [srrip_pkg::STAT_W-1:0] sat_inc(
        logic [srrip_pkg::STAT_W-1:0] v);
        return (v == srrip_pkg::STAT_MAX) ? v : v + 1'b1;
    endfunction

    // expected result of one accepted request, advancing the predicted state
    task automatic predict_access(request_t rq);
        int unsigned s;
        logic srrip_ld, fifo_ld, pol, do_switch;
        logic [srrip_pkg::RRPV_W-1:0] top_rrpv;
        logic [srrip_pkg::AGE_W-1:0] top_age;
        logic [srrip_pkg::WAY_W-1:0] victim;
        logic [63:0] sn, sd, fn, fd;
        int p;
        result_t res;
        s = rq.set_index;
        srrip_ld = s < leaders_each;
        fifo_ld = !srrip_ld && s < 2 * leaders_each;
        pol = srrip_ld ? srrip_pkg::POL_SRRIP : fifo_ld ? srrip_pkg::POL_FIFO : set_policy[s];
        victim = '0;
        if (rq.cmd == srrip_pkg::CMD_QUERY) begin
            if (pol == srrip_pkg::POL_SRRIP) begin
                top_rrpv = rrpv_row[s][0];
                for (int w = 1; w < srrip_pkg::NUM_WAYS; w++)
                    if (rrpv_row[s][w] > top_rrpv) begin
                        top_rrpv = rrpv_row[s][w];
                        victim = srrip_pkg::WAY_W'(w);
                    end
                for (int w = 0; w < srrip_pkg::NUM_WAYS; w++)
                    rrpv_row[s][w] = rrpv_row[s][w] + (srrip_pkg::RRPV_MAX - top_rrpv);
            end
            else begin
                top_age = age_row[s][0];
                for (int w = 1; w < srrip_pkg::NUM_WAYS; w++)
                    if (age_row[s][w] > top_age) begin
                        top_age = age_row[s][w];
                        victim = srrip_pkg::WAY_W'(w);
                    end
            end
        end
        else begin
            access_count = access_count + 1'b1;
            if (srrip_ld) begin
                srrip_accesses = sat_inc(srrip_accesses);
                if (rq.was_hit) srrip_hits = sat_inc(srrip_hits);
            end
            else if (fifo_ld) begin
                fifo_accesses = sat_inc(fifo_accesses);
                if (rq.was_hit) fifo_hits = sat_inc(fifo_hits);
            end
            else begin
                p = (period_log2 > srrip_pkg::PERIOD_MAX) ? srrip_pkg::PERIOD_MAX
                                                          : period_log2;
                do_switch = (access_count & ((1 << p) - 1)) == 0;
                if (do_switch) begin
                    // empty leader group counts as rate zero
                    sn = srrip_accesses != 0 ? srrip_hits : 0;
                    sd = srrip_accesses != 0 ? srrip_accesses : 1;
                    fn = fifo_accesses != 0 ? fifo_hits : 0;
                    fd = fifo_accesses != 0 ? fifo_accesses : 1;
                    set_policy[s] = (sn * fd >= fn * sd) ? srrip_pkg::POL_SRRIP
                                                         : srrip_pkg::POL_FIFO;
                end
            end
            if (pol == srrip_pkg::POL_SRRIP) begin
                rrpv_row[s][rq.way_index] = rq.was_hit ? srrip_pkg::RRPV_HIT
                                                       : srrip_pkg::RRPV_INSERT;
                age_row[s][rq.way_index] = '0;
            end
            else if (rq.was_hit) begin
                age_row[s][rq.way_index] = '0;
            end
            else begin
                // fifo miss: the others age, saturating
                for (int w = 0; w < srrip_pkg::NUM_WAYS; w++)
                    if (w == rq.way_index) age_row[s][w] = '0;
                    else if (age_row[s][w] != srrip_pkg::AGE_MAX) age_row[s][w]++;
                rrpv_row[s][rq.way_index] = srrip_pkg::RRPV_MAX;
            end
        end
        res.victim = victim;
        res.policy = pol;
        expected_result.push_back(res);
    endtask

    task automatic report_mismatch(string what, int got, int want);
        $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $time);
        error_count++;
    endtask

    // request acceptance and prediction
    always @(posedge clk)
        if (s_tvalid && s_tready) begin
            in_taken = 1'b1;
            predict_access(pending_req.pop_front());
        end

    // request driver
    always @(negedge clk) begin
        if (!s_tvalid || in_taken) begin
            in_taken = 1'b0;
            if (send_gap > 0 || hold_send || pending_req.size() == 0) begin
                if (send_gap > 0) send_gap <= send_gap - 1;
                s_tvalid <= 1'b0;
            end
            else begin
                s_tvalid <= 1'b1;
                s_tuser <= pending_req[0].cmd;
                s_tdata <= {pending_req[0].was_hit, pending_req[0].way_index,
                            pending_req[0].set_index};
                send_gap <= pick_gap();
            end
        end
    end

    // result stall generator
    always @(negedge clk) begin
        if (recv_gap > 0) begin
            recv_gap <= recv_gap - 1;
            m_tready <= 1'b0;
        end
        else begin
            m_tready <= 1'b1;
            if ($urandom_range(0, 3) == 0) recv_gap <= pick_gap();
        end
    end

    // result monitor
    always @(posedge clk)
        if (m_tvalid && m_tready) begin
            if (expected_result.size() == 0) begin
                report_mismatch("unexpected beat, victim", m_tdata[3:0], 0);
            end
            else begin
                result_t want;
                want = expected_result.pop_front();
                if (m_tdata[3:0] !== want.victim)
                    report_mismatch("victim_way", m_tdata[3:0], want.victim);
                if (m_tuser !== want.policy)
                    report_mismatch("policy_used", m_tuser, want.policy);
                if (m_tdata[7:4] !== 4'd0)
                    report_mismatch("zero fill", m_tdata[7:4], 0);
            end
        end

    task automatic write_reg(logic idx, logic [10:0] value);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        do @(posedge clk); while (!cfg_ready);
        if (idx == srrip_pkg::CFG_LEADERS) leaders_each = value;
        else period_log2 = value[srrip_pkg::PERIOD_W-1:0];
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic wait_drained();
        while (pending_req.size() != 0 || expected_result.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
    endtask

    task automatic queue_req(logic cmd, int s, int w, logic hit);
        request_t rq;
        rq.cmd = cmd;
        rq.set_index = srrip_pkg::SET_W'(s);
        rq.way_index = srrip_pkg::WAY_W'(w);
        rq.was_hit = hit;
        pending_req.push_back(rq);
    endtask

    // set choice weighted toward a few leaders and followers so rows fill up
    function automatic int pick_set();
        int r;
        int l;
        l = leaders_each;
        r = $urandom_range(0, 99);
        if (r < 10) return $urandom_range(0, srrip_pkg::NUM_SETS - 1);
        if (r < 45 && l > 0) return $urandom_range(0, (l < 4 ? l : 4) - 1);
        if (r < 70 && l > 0 && l < srrip_pkg::NUM_SETS) return l + $urandom_range(0, 3) % l;
        return (2 * l + $urandom_range(0, 5)) % srrip_pkg::NUM_SETS;
    endfunction

    task automatic queue_random(int count);
        for (int i = 0; i < count; i++) begin
            if ($urandom_range(0, 99) < 35)
                queue_req(srrip_pkg::CMD_QUERY, pick_set(), $urandom_range(0, 15),
                          1'($urandom_range(0, 1)));
            else
                queue_req(srrip_pkg::CMD_UPDATE, pick_set(), $urandom_range(0, 15),
                          1'($urandom_range(0, 1)));
        end
    endtask

    task automatic run_phase(int leaders, int period, int count, bit pause_midway);
        write_reg(srrip_pkg::CFG_LEADERS, 11'(leaders));
        write_reg(srrip_pkg::CFG_PERIOD, 11'(period));
        no_idle = $urandom_range(0, 3) == 0;
        if (pause_midway) begin
            queue_random(count / 2);
            wait_drained();
            queue_random(count - count / 2);
        end
        else begin
            queue_random(count);
        end
        wait_drained();
    endtask

    initial begin
        clk = 1'b0;
        rst_n = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tuser = 1'b0;
        m_tready = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = 1'b0;
        cfg_data = '0;
        hold_send = 1'b0;
        no_idle = 1'b0;
        in_taken = 1'b0;
        send_gap = 0;
        recv_gap = 0;
        error_count = 0;
        for (int s = 0; s < srrip_pkg::NUM_SETS; s++) begin
            set_policy[s] = srrip_pkg::POL_SRRIP;
            for (int w = 0; w < srrip_pkg::NUM_WAYS; w++) begin
                rrpv_row[s][w] = srrip_pkg::RRPV_MAX;
                age_row[s][w] = '0;
            end
        end
        srrip_hits = '0;
        srrip_accesses = '0;
        fifo_hits = '0;
        fifo_accesses = '0;
        access_count = '0;
        leaders_each = srrip_pkg::LEADERS_RESET;
        period_log2 = srrip_pkg::PERIOD_RESET;
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed: field extremes, both policies, hit and miss, followers
        queue_req(srrip_pkg::CMD_QUERY, 0, 0, 0);
        queue_req(srrip_pkg::CMD_QUERY, srrip_pkg::NUM_SETS - 1, 15, 1);
        queue_req(srrip_pkg::CMD_UPDATE, 0, 15, 1);
        queue_req(srrip_pkg::CMD_UPDATE, 0, 0, 0);
        queue_req(srrip_pkg::CMD_QUERY, 0, 0, 0);
        queue_req(srrip_pkg::CMD_UPDATE, 32, 3, 0);
        queue_req(srrip_pkg::CMD_UPDATE, 32, 5, 0);
        queue_req(srrip_pkg::CMD_UPDATE, 32, 3, 1);
        queue_req(srrip_pkg::CMD_QUERY, 32, 0, 0);
        queue_req(srrip_pkg::CMD_UPDATE, 63, 15, 1);
        queue_req(srrip_pkg::CMD_UPDATE, 64, 7, 1);
        queue_req(srrip_pkg::CMD_UPDATE, srrip_pkg::NUM_SETS - 1, 15, 0);
        queue_req(srrip_pkg::CMD_QUERY, srrip_pkg::NUM_SETS - 1, 0, 0);
        queue_req(srrip_pkg::CMD_QUERY, 1365, 10, 0);
        queue_req(srrip_pkg::CMD_UPDATE, 682, 5, 1);
        wait_drained();

        run_phase(32, 12, 200, 1'b0);
        run_phase(0, 0, 200, 1'b0);
        run_phase(1024, 31, 150, 1'b0);
        run_phase(4, 1, 300, 1'b1);
        run_phase(2047, 3, 100, 1'b0);
        run_phase(8, 2, 300, 1'b0);

        if (error_count == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

    // watchdog
    initial begin
        #6000000;
        $display("Regression FAIL");
        $finish;
    end

endmodule
